// ===== rtl/core/nds_pkg.sv =====
`default_nettype none
package nds_pkg;
  localparam int MaxPoints    = 64;
  localparam int MakespanBits = 32;
  localparam int CostBits     = 48;
  localparam int IdxBits      = 6;
  localparam int CntBits      = 7;
  localparam int RankBits     = 6;

  typedef logic [IdxBits-1:0]  idx_t;
  typedef logic [CntBits-1:0]  cnt_t;
  typedef logic [RankBits-1:0] rank_t;

  typedef struct packed {
    logic [MakespanBits-1:0] makespan;
    logic [CostBits-1:0]     cost;
  } point_t;

  // a beats b: no worse in both objectives, strictly better in one
  function automatic logic beats(point_t a, point_t b);
    logic no_worse;
    logic better;
    no_worse = (a.makespan <= b.makespan) && (a.cost <= b.cost);
    better   = (a.makespan < b.makespan) || (a.cost < b.cost);
    return no_worse && better;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/nds_if.sv =====
`default_nettype none
interface nds_in_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] makespan;
  logic [47:0] cost;
  logic        final_point;
  modport source (output valid, makespan, cost, final_point, input ready);
  modport sink (input valid, makespan, cost, final_point, output ready);
endinterface

interface nds_out_if (input wire logic clk);
  logic       valid;
  logic       ready;
  logic [5:0] point_index;
  logic [5:0] front_rank;
  logic       dropped;
  logic       end_of_set;
  modport source (output valid, point_index, front_rank, dropped, end_of_set, input ready);
  modport sink (input valid, point_index, front_rank, dropped, end_of_set, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nondominated_sort_ranking.sv =====
`default_nettype none
// Channel  Dir  Fields
// in_ch    in   makespan[32], cost[48], final_point
// out_ch   out  point_index[6], front_rank[6], dropped, end_of_set
// Loading takes one cycle per transfer; in_ch.ready is high only while loading.
// On the final point the n stored points are ranked: each ordered pair is read
// and compared to build the dominance rows and counts, then one round per front
// reads each front row, scans its bits and decrements the count of each point
// it dominates. Each result is read from the working memory and held on out_ch
// until out_ch.ready; no input is taken until the last result transfers.
// Synchronous reset clears the count, the drop flag, the sequencer and out valid.
module nondominated_sort_ranking (
  input wire logic  clk,
  input wire logic  rst,
  nds_in_if.sink    in_ch,
  nds_out_if.source out_ch
);
  typedef enum logic [3:0] {
    LOAD, CMP_RD, CMP_EV, PEEL_P, PEEL_ROW, PEEL_Q, PEEL_UPD, PEEL_NEXT,
    EMIT_RD, EMIT_LD, EMIT
  } state_t;

  typedef logic [nds_pkg::MaxPoints-1:0] mask_t;

  // per-point working word: points it dominates, dominator count, rank
  typedef struct packed {
    mask_t          row;
    nds_pkg::cnt_t  cnt;
    nds_pkg::rank_t rank;
  } stat_t;

  state_t          state;
  nds_pkg::point_t pts [nds_pkg::MaxPoints];
  stat_t           stat_mem [nds_pkg::MaxPoints];

  nds_pkg::point_t pt_a, pt_b;
  stat_t           stat_rd;
  stat_t           stat_wdata;
  stat_t           upd_word;
  nds_pkg::idx_t   stat_addr;
  logic            stat_we;

  mask_t          row, row_next;
  mask_t          front, next_front;
  nds_pkg::cnt_t  acc, acc_next;
  nds_pkg::cnt_t  point_count;
  logic           overflow_seen;
  nds_pkg::idx_t  p, q;
  nds_pkg::rank_t r;
  logic           a_beats_b, b_beats_a;
  logic           take, room, last_p, last_q, upd_hit, upd_zero;

  assign in_ch.ready = (state == LOAD);
  assign take = in_ch.valid && in_ch.ready;
  assign room = point_count < nds_pkg::CntBits'(nds_pkg::MaxPoints);
  assign last_q = ({1'b0, q} + 7'd1) == point_count;
  assign last_p = ({1'b0, p} + 7'd1) == point_count;

  // dual-read point memory
  always_ff @(posedge clk) begin
    if (take && room) begin
      pts[point_count[nds_pkg::IdxBits-1:0]] <= {in_ch.makespan, in_ch.cost};
    end
    pt_a <= pts[p];
    pt_b <= pts[q];
  end

  assign a_beats_b = nds_pkg::beats(pt_a, pt_b);
  assign b_beats_a = nds_pkg::beats(pt_b, pt_a);
  // first column starts a fresh row and count
  assign row_next = ((q == '0) ? '0 : row) | (a_beats_b ? (mask_t'(1) << q) : '0);
  assign acc_next = ((q == '0) ? '0 : acc) + (b_beats_a ? 7'd1 : 7'd0);

  assign upd_hit  = stat_rd.cnt != '0;
  assign upd_zero = stat_rd.cnt == 7'd1;

  always_comb begin
    upd_word = stat_rd;
    if (upd_hit) begin
      upd_word.cnt = stat_rd.cnt - 7'd1;
    end
    if (upd_zero) begin
      upd_word.rank = r + 6'd1;
    end
  end

  always_comb begin
    stat_wdata = upd_word;
    if (state != PEEL_UPD) begin
      stat_wdata.row  = row_next;
      stat_wdata.cnt  = acc_next;
      stat_wdata.rank = '0;
    end
  end

  // peel updates address the dominated point, everything else the row
  assign stat_addr = (state == PEEL_Q || state == PEEL_UPD) ? q : p;
  assign stat_we   = (state == CMP_EV && last_q) || (state == PEEL_UPD);

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[stat_addr] <= stat_wdata;
    end
    stat_rd <= stat_mem[stat_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= LOAD;
      point_count   <= '0;
      overflow_seen <= 1'b0;
      out_ch.valid  <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (take) begin
            if (room) begin
              point_count <= point_count + 7'd1;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (in_ch.final_point) begin
              p     <= '0;
              q     <= '0;
              front <= '0;
              state <= CMP_RD;
            end
          end
        end
        CMP_RD: begin
          state <= CMP_EV;
        end
        CMP_EV: begin
          row <= row_next;
          acc <= acc_next;
          if (!last_q) begin
            q     <= q + 6'd1;
            state <= CMP_RD;
          end else begin
            front[p] <= (acc_next == '0);
            q        <= '0;
            if (!last_p) begin
              p     <= p + 6'd1;
              state <= CMP_RD;
            end else begin
              p          <= '0;
              r          <= '0;
              next_front <= '0;
              state      <= PEEL_P;
            end
          end
        end
        PEEL_P: begin
          state <= front[p] ? PEEL_ROW : PEEL_NEXT;
        end
        PEEL_ROW: begin
          row   <= stat_rd.row;
          q     <= '0;
          state <= PEEL_Q;
        end
        PEEL_Q: begin
          // drop each set bit as its count update starts
          if (row[q]) begin
            row[q] <= 1'b0;
            state  <= PEEL_UPD;
          end else if (!last_q) begin
            q <= q + 6'd1;
          end else begin
            state <= PEEL_NEXT;
          end
        end
        PEEL_UPD: begin
          if (upd_zero) begin
            next_front[q] <= 1'b1;
          end
          state <= PEEL_Q;
        end
        PEEL_NEXT: begin
          if (!last_p) begin
            p     <= p + 6'd1;
            state <= PEEL_P;
          end else if (next_front == '0) begin
            p     <= '0;
            state <= EMIT_RD;
          end else begin
            front      <= next_front;
            next_front <= '0;
            r          <= r + 6'd1;
            p          <= '0;
            state      <= PEEL_P;
          end
        end
        EMIT_RD: begin
          state <= EMIT_LD;
        end
        EMIT_LD: begin
          out_ch.valid       <= 1'b1;
          out_ch.point_index <= p;
          out_ch.front_rank  <= stat_rd.rank;
          out_ch.dropped     <= overflow_seen;
          out_ch.end_of_set  <= last_p;
          state              <= EMIT;
        end
        EMIT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (out_ch.end_of_set) begin
              point_count   <= '0;
              overflow_seen <= 1'b0;
              state         <= LOAD;
            end else begin
              p     <= p + 6'd1;
              state <= EMIT_RD;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  typedef struct packed {
    nds_pkg::idx_t  point_index;
    nds_pkg::rank_t front_rank;
    logic           dropped;
    logic           end_of_set;
  } ranking_t;

  logic clk;
  logic rst;
  nds_in_if  in_ch (clk);
  nds_out_if out_ch (clk);

  nondominated_sort_ranking u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // predictor copy of the loaded set
  logic [nds_pkg::MakespanBits-1:0] held_ms [nds_pkg::MaxPoints];
  logic [nds_pkg::CostBits-1:0]     held_cost [nds_pkg::MaxPoints];
  int                               held_count;
  logic                             held_overflow;
  ranking_t                         ranking_q [$];
  int                               fail_count;
  bit                               no_idle;

  function automatic bit dominates(int a, int b);
    return (held_ms[a] <= held_ms[b]) && (held_cost[a] <= held_cost[b]) &&
           ((held_ms[a] < held_ms[b]) || (held_cost[a] < held_cost[b]));
  endfunction

  task automatic rank_held_set();
    logic [nds_pkg::MaxPoints-1:0] beaten [nds_pkg::MaxPoints];
    int                            above [nds_pkg::MaxPoints];
    int                            rank_of [nds_pkg::MaxPoints];
    logic [nds_pkg::MaxPoints-1:0] front;
    logic [nds_pkg::MaxPoints-1:0] next_front;
    int                            r;
    ranking_t                      e;
    front = '0;
    for (int p = 0; p < held_count; p++) begin
      beaten[p] = '0;
      above[p] = 0;
      rank_of[p] = 0;
      for (int q = 0; q < held_count; q++) begin
        if (p == q) continue;
        if (dominates(p, q)) beaten[p][q] = 1'b1;
        else if (dominates(q, p)) above[p]++;
      end
      if (above[p] == 0) front[p] = 1'b1;
    end
    r = 0;
    while (front != '0 && r < 64) begin
      next_front = '0;
      for (int p = 0; p < held_count; p++) begin
        if (!front[p]) continue;
        for (int q = 0; q < held_count; q++) begin
          if (beaten[p][q] && above[q] > 0) begin
            above[q]--;
            if (above[q] == 0) begin
              rank_of[q] = (r + 1) & 63;
              next_front[q] = 1'b1;
            end
          end
        end
      end
      front = next_front;
      r++;
    end
    for (int k = 0; k < held_count; k++) begin
      e.point_index = nds_pkg::idx_t'(k);
      e.front_rank  = nds_pkg::rank_t'(rank_of[k]);
      e.dropped     = held_overflow;
      e.end_of_set  = (k + 1 == held_count);
      ranking_q = {ranking_q, e};
    end
    held_count = 0;
    held_overflow = 1'b0;
  endtask

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_point(logic [31:0] ms, logic [47:0] c, logic fin);
    bit acc;
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.makespan    <= ms;
    in_ch.cost        <= c;
    in_ch.final_point <= fin;
    do begin
      @(negedge clk);
      acc = in_ch.ready;
      @(posedge clk);
    end while (!acc);
    if (held_count < nds_pkg::MaxPoints) begin
      held_ms[held_count]   = ms;
      held_cost[held_count] = c;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (fin) rank_held_set();
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst || no_idle) out_ch.ready <= 1'b1;
    else if (r < 3) out_ch.ready <= 1'b0;
    else if (r < 25) out_ch.ready <= ~out_ch.ready;
    else if (r < 30) out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    ranking_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (ranking_q.size() == 0) begin
        report($sformatf("unexpected result index %0d", out_ch.point_index));
      end else begin
        e = ranking_q.pop_front();
        if (out_ch.point_index !== e.point_index)
          report($sformatf("point_index %0d, want %0d",
                           out_ch.point_index, e.point_index));
        if (out_ch.front_rank !== e.front_rank)
          report($sformatf("front_rank %0d, want %0d (index %0d)",
                           out_ch.front_rank, e.front_rank, e.point_index));
        if (out_ch.dropped !== e.dropped)
          report($sformatf("dropped %0b, want %0b", out_ch.dropped, e.dropped));
        if (out_ch.end_of_set !== e.end_of_set)
          report($sformatf("end_of_set %0b, want %0b",
                           out_ch.end_of_set, e.end_of_set));
      end
    end
  end

  function automatic logic [31:0] rand_ms(bit narrow);
    return narrow ? 32'($urandom_range(0, 7)) : $urandom;
  endfunction

  function automatic logic [47:0] rand_cost(bit narrow);
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    return narrow ? 48'($urandom_range(0, 7)) : v;
  endfunction

  task automatic test_extremes();
    send_point(32'd0, 48'd0, 1'b1);
    send_point('1, '1, 1'b0);
    send_point(32'd0, '1, 1'b0);
    send_point('1, 48'd0, 1'b0);
    send_point(32'h5555_5555, 48'h5555_5555_5555, 1'b0);
    send_point(32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 1'b0);
    send_point('1, '1, 1'b1);
  endtask

  task automatic test_equal_and_chain();
    // identical points share a rank; a chain gives one front per point
    send_point(32'd5, 48'h1_0000, 1'b0);
    send_point(32'd5, 48'h1_0000, 1'b0);
    send_point(32'd3, 48'h0_8000, 1'b0);
    send_point(32'd5, 48'h0_8000, 1'b0);
    send_point(32'd3, 48'h1_0000, 1'b0);
    send_point(32'd9, 48'h2_0000, 1'b0);
    send_point(32'd2, 48'h3_0000, 1'b1);
  endtask

  task automatic test_full_chain();
    // 64 points in a strict chain: ranks 63 down to 0
    for (int i = 0; i < nds_pkg::MaxPoints; i++)
      send_point(32'(nds_pkg::MaxPoints - 1 - i), 48'(nds_pkg::MaxPoints - 1 - i),
                 i == nds_pkg::MaxPoints - 1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < nds_pkg::MaxPoints + 2; i++)
      send_point(rand_ms(1), rand_cost(1), i == nds_pkg::MaxPoints + 1);
    // final point itself dropped
    for (int i = 0; i <= nds_pkg::MaxPoints; i++)
      send_point(rand_ms(i[0]), rand_cost(i[1]), i == nds_pkg::MaxPoints);
  endtask

  task automatic test_random_sets();
    int sent;
    int n;
    bit narrow;
    sent = 0;
    while (sent < 250) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
      narrow = ($urandom_range(0, 3) != 0);
      no_idle = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < n; i++)
        send_point(rand_ms(narrow), rand_cost(narrow), i == n - 1);
      sent += n;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.makespan = '0;
    in_ch.cost = '0;
    in_ch.final_point = 1'b0;
    out_ch.ready = 1'b1;
    held_count = 0;
    held_overflow = 1'b0;
    fail_count = 0;
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_equal_and_chain();
    test_full_chain();
    test_overflow();
    test_random_sets();
    in_ch.valid <= 1'b0;
    waited = 0;
    while (ranking_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && ranking_q.size() == 0) begin
      $display("PASS nondominated_sort_ranking");
    end else begin
      $display("FAIL nondominated_sort_ranking");
    end
    $finish;
  end

  initial begin
    #(64'd8 * 64'd2_000_000);
    $display("FAIL nondominated_sort_ranking");
    $finish;
  end
endmodule
